[sv/taf_pkg.sv]
// shared types, constants and the tanh segment tables of the tanh activation unit
`default_nettype none

package taf_pkg;

  // segments per unit of |x|, as a power of two
  localparam int SEG_BITS = 5;
  localparam int ROM_ENTRIES = 257;
  localparam int SEG_COUNT = 256;
  localparam int BASE_W = 17;
  localparam int DIFF_W = 12;

  typedef logic [ROM_ENTRIES-1:0][BASE_W-1:0] tanh_rom_t;
  typedef logic [SEG_COUNT-1:0][BASE_W-1:0] base_tab_t;
  typedef logic [SEG_COUNT-1:0][DIFF_W-1:0] diff_tab_t;

  // shift-subtract quotient, used only while the tables are elaborated
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] quo;
    logic [64:0] rem;
    quo = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem = rem - {1'b0, den};
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // tanh(k/32) in unsigned Q1.16, from a series for e^-(1/16) and repeated products
  function automatic tanh_rom_t build_rom();
    tanh_rom_t rom;
    logic [63:0] pos;
    logic [63:0] neg;
    logic [63:0] term;
    logic [63:0] step32;
    logic [63:0] e;
    logic [63:0] num;
    logic [63:0] den;
    logic [63:0] quo;
    logic [127:0] prod;
    pos = 64'd1 << 62;
    neg = '0;
    term = 64'd1 << 62;
    for (int n = 1; n <= 12; n++) begin
      term = udiv64(term, 64'(16 * n));
      if ((n % 2) == 1) begin
        neg = neg + term;
      end else begin
        pos = pos + term;
      end
    end
    step32 = ((pos - neg) + (64'd1 << 29)) >> 30;
    e = 64'd1 << 32;
    for (int k = 0; k < ROM_ENTRIES; k++) begin
      num = ((64'd1 << 32) - e) << 16;
      den = (64'd1 << 32) + e;
      quo = udiv64(num + (den >> 1), den);
      rom[k] = quo[BASE_W-1:0];
      prod = {64'd0, e} * {64'd0, step32};
      prod = (prod + (128'd1 << 31)) >> 32;
      e = prod[63:0];
    end
    return rom;
  endfunction

  localparam tanh_rom_t TANH_ROM = build_rom();

  // segment start values
  function automatic base_tab_t build_base(input tanh_rom_t rom);
    base_tab_t tab;
    for (int k = 0; k < SEG_COUNT; k++) begin
      tab[k] = rom[k];
    end
    return tab;
  endfunction

  // segment slopes, rise over one segment
  function automatic diff_tab_t build_diff(input tanh_rom_t rom);
    diff_tab_t tab;
    logic [BASE_W-1:0] rise;
    for (int k = 0; k < SEG_COUNT; k++) begin
      rise = rom[k+1] - rom[k];
      tab[k] = rise[DIFF_W-1:0];
    end
    return tab;
  endfunction

  localparam base_tab_t BASE_TAB = build_base(TANH_ROM);
  localparam diff_tab_t DIFF_TAB = build_diff(TANH_ROM);

  typedef enum logic {
    OP_FORWARD  = 1'b0,
    OP_BACKWARD = 1'b1
  } op_e;

endpackage

`default_nettype wire

[sv/taf_ram.sv]
// generic single-write, single-read ram with registered read data
`default_nettype none

module taf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  wire                                         clk_i,
  input  wire                                         we_i,
  input  wire  [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0]  waddr_i,
  input  wire  [WIDTH-1:0]                            wdata_i,
  input  wire                                         re_i,
  input  wire  [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0]  raddr_i,
  output logic [WIDTH-1:0]                            rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port, holds while not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[sv/tanh_activation_fwd_bwd_top.sv]
// tanh activation unit, forward tanh and backward gradient, fully pipelined
//
// Input beats arrive on s_axis: tuser selects forward (0) or backward (1),
// tdata carries the element index and the Q4.12 value. Each beat gives one
// result beat on m_axis carrying the 16-bit result, in input order.
// Forward beats return tanh(value) from a 256-segment table with linear
// interpolation; with training mode set they also store the result at the
// element index, if in range. Backward beats read the stored output t and
// return value * (1 - t*t), rounded and saturated.
// The cfg channel writes the one-bit training mode; it is always ready.
// Throughput is one beat per cycle while the receiver takes results. A beat
// passes input, table, interpolation, ram read, 1 - t*t, gradient product
// and output register. The store is written and read at the same stage,
// so a backward beat directly after its forward beat sees it.
// Reset clears all valid bits and training mode; the store is not cleared.
// When the receiver stalls, the whole pipeline holds and s_axis_tready falls.
`default_nettype none

module tanh_activation_fwd_bwd_top #(
  parameter int ELEMENT_DEPTH = 4096,
  parameter int FRACTION_BITS = 12
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  // configuration write
  input  wire         cfg_valid_i,
  output logic        cfg_ready_o,
  input  wire         cfg_data_i,     // training_mode
  // input beats
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [31:0] s_axis_tdata,   // [11:0] element_index, [27:12] value, [31:28] zero
  input  wire  [0:0]  s_axis_tuser,   // [0] operation
  // result beats
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [15:0] m_axis_tdata    // [15:0] result_value
);

  import taf_pkg::*;

  localparam int SHIFT = FRACTION_BITS - SEG_BITS;
  localparam int PW = DIFF_W + SHIFT;
  localparam int AW = (ELEMENT_DEPTH > 1) ? $clog2(ELEMENT_DEPTH) : 1;
  localparam int TWO_F = 2 * FRACTION_BITS;

  logic adv;
  logic train_q;

  // stage registers
  logic        p1_valid_q, p2_valid_q, p3_valid_q, p4_valid_q, p5_valid_q, p6_valid_q;
  logic        out_valid_q;
  op_e         p1_op_q, p2_op_q, p3_op_q, p4_op_q, p5_op_q, p6_op_q;
  logic [11:0] p1_idx_q, p2_idx_q, p3_idx_q;
  logic signed [15:0] p1_val_q, p2_val_q, p3_val_q, p4_val_q, p5_val_q;
  logic [15:0] p3_fwd_q, p4_fwd_q, p5_fwd_q, p6_fwd_q;
  logic [BASE_W-1:0] p2_base_q;
  logic [DIFF_W-1:0] p2_diff_q;
  logic [SHIFT-1:0]  p2_fr_q;
  logic        p2_large_q, p2_neg_q;
  logic        p4_oor_q;
  logic signed [31:0] p5_d_q;
  logic signed [47:0] p6_prod_q;
  logic [15:0] out_data_q;

  // global advance: the pipeline moves when the output slot is free or taken
  assign adv = !out_valid_q || m_axis_tready;
  assign s_axis_tready = adv;
  assign cfg_ready_o = 1'b1;

  // training mode register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      train_q <= 1'b0;
    end else if (cfg_valid_i) begin
      train_q <= cfg_data_i;
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_valid_q  <= 1'b0;
      p2_valid_q  <= 1'b0;
      p3_valid_q  <= 1'b0;
      p4_valid_q  <= 1'b0;
      p5_valid_q  <= 1'b0;
      p6_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      p1_valid_q  <= s_axis_tvalid;
      p2_valid_q  <= p1_valid_q;
      p3_valid_q  <= p2_valid_q;
      p4_valid_q  <= p3_valid_q;
      p5_valid_q  <= p4_valid_q;
      p6_valid_q  <= p5_valid_q;
      out_valid_q <= p6_valid_q;
    end
  end

  // stage 1: capture the input beat
  always_ff @(posedge clk_i) begin
    if (adv) begin
      p1_op_q  <= op_e'(s_axis_tuser[0]);
      p1_idx_q <= s_axis_tdata[11:0];
      p1_val_q <= s_axis_tdata[27:12];
    end
  end

  // stage 2: magnitude, segment split and table lookup
  logic [15:0] mag;
  logic [15:0] seg_full;
  logic [7:0]  seg_idx;

  always_comb begin
    mag = p1_val_q[15] ? 16'(-p1_val_q) : 16'(p1_val_q);
    seg_full = mag >> SHIFT;
    seg_idx = seg_full[7:0];
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p2_op_q    <= p1_op_q;
      p2_idx_q   <= p1_idx_q;
      p2_val_q   <= p1_val_q;
      p2_base_q  <= BASE_TAB[seg_idx];
      p2_diff_q  <= DIFF_TAB[seg_idx];
      p2_fr_q    <= mag[SHIFT-1:0];
      p2_large_q <= (seg_full[15:8] != 8'd0);
      p2_neg_q   <= p1_val_q[15];
    end
  end

  // stage 3: interpolate, round to the output format and apply the sign
  logic [PW-1:0] interp_prod;
  logic [PW:0]   interp_rnd;
  logic [PW:0]   interp;
  logic [17:0]   t16;
  logic [17:0]   t_rnd;
  logic [17:0]   t_out;
  logic [15:0]   fwd_res;

  always_comb begin
    interp_prod = PW'(p2_diff_q) * PW'(p2_fr_q);
    interp_rnd = {1'b0, interp_prod} + ((PW+1)'(1) << (SHIFT - 1));
    interp = interp_rnd >> SHIFT;
    if (p2_large_q) begin
      t16 = 18'd65536;
    end else begin
      t16 = 18'(p2_base_q) + 18'(interp);
    end
    t_rnd = t16 + (18'd1 << (15 - FRACTION_BITS));
    t_out = t_rnd >> (16 - FRACTION_BITS);
    fwd_res = p2_neg_q ? 16'(-t_out[15:0]) : t_out[15:0];
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p3_op_q  <= p2_op_q;
      p3_idx_q <= p2_idx_q;
      p3_val_q <= p2_val_q;
      p3_fwd_q <= fwd_res;
    end
  end

  // stage 4: forward store or backward read of the saved output
  logic [AW+11:0] idx_ext;
  logic [AW-1:0]  ram_addr;
  logic           in_range;
  logic           ram_we;
  logic           ram_re;
  logic [15:0]    ram_rdata;

  always_comb begin
    idx_ext = {{AW{1'b0}}, p3_idx_q};
    ram_addr = idx_ext[AW-1:0];
    in_range = (32'(p3_idx_q) < 32'(ELEMENT_DEPTH));
    ram_we = adv && p3_valid_q && (p3_op_q == OP_FORWARD) && train_q && in_range;
    ram_re = adv && p3_valid_q && (p3_op_q == OP_BACKWARD);
  end

  taf_ram #(
    .WIDTH (16),
    .DEPTH (ELEMENT_DEPTH)
  ) u_saved (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_addr),
    .wdata_i (p3_fwd_q),
    .re_i    (ram_re),
    .raddr_i (ram_addr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p4_op_q  <= p3_op_q;
      p4_val_q <= p3_val_q;
      p4_fwd_q <= p3_fwd_q;
      p4_oor_q <= !in_range;
    end
  end

  // stage 5: derivative factor 1 - t*t
  logic signed [15:0] t_val;
  logic signed [31:0] t_sq;

  always_comb begin
    t_val = p4_oor_q ? 16'sd0 : $signed(ram_rdata);
    t_sq = t_val * t_val;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p5_op_q  <= p4_op_q;
      p5_val_q <= p4_val_q;
      p5_fwd_q <= p4_fwd_q;
      p5_d_q   <= (32'sd1 <<< TWO_F) - t_sq;
    end
  end

  // stage 6: gradient product
  always_ff @(posedge clk_i) begin
    if (adv) begin
      p6_op_q   <= p5_op_q;
      p6_fwd_q  <= p5_fwd_q;
      p6_prod_q <= 48'(p5_val_q) * 48'(p5_d_q);
    end
  end

  // output stage: round away from zero, saturate, pick the result
  logic        prod_neg;
  logic [47:0] prod_mag;
  logic [47:0] q_rnd;
  logic [47:0] q_val;
  logic [15:0] bwd_res;

  always_comb begin
    prod_neg = p6_prod_q[47];
    prod_mag = prod_neg ? 48'(-p6_prod_q) : 48'(p6_prod_q);
    q_rnd = prod_mag + (48'd1 << (TWO_F - 1));
    q_val = q_rnd >> TWO_F;
    if (prod_neg) begin
      if (q_val > 48'd32768) begin
        bwd_res = 16'h8000;
      end else begin
        bwd_res = 16'(-q_val[15:0]);
      end
    end else begin
      if (q_val > 48'd32767) begin
        bwd_res = 16'h7fff;
      end else begin
        bwd_res = q_val[15:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_data_q <= (p6_op_q == OP_BACKWARD) ? bwd_res : p6_fwd_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata = out_data_q;

endmodule

`default_nettype wire
